[sv/connection_slot_cache_lru_aging_defines.svh]
// assertion macros for the connection slot cache checker
// no dependencies; included by the checker file only
`ifndef CONNECTION_SLOT_CACHE_LRU_AGING_DEFINES_SVH
`define CONNECTION_SLOT_CACHE_LRU_AGING_DEFINES_SVH

// same-cycle implication
`define CSLRU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSLRU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/cslru_pkg.sv]
// shared types and constants for the connection slot cache
// used by the interfaces, controller, datapath, top level and checker
package cslru_pkg;

  localparam int OP_W        = 2;
  localparam int CONN_W      = 8;
  localparam int PORT_TIME_W = 32;
  localparam int KIND_W      = 3;
  localparam int SLOT_W      = 4;
  localparam int SIU_W       = 5;
  localparam int TIMEOUT_W   = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_SLOTS_IN_USE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TIMEOUT = 1'd1;

  localparam logic [SIU_W-1:0]     SIU_RESET     = 5'd16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd300;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLOSE     = 3'd0,
    KIND_STORED    = 3'd1,
    KIND_CACHED    = 3'd2,
    KIND_OFF       = 3'd3,
    KIND_UPDATED   = 3'd4,
    KIND_NOT_FOUND = 3'd5,
    KIND_FLUSHED   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_START,
    ACT_STEP,
    ACT_DROP,
    ACT_FINISH
  } act_t;

  typedef struct packed {
    logic direct;
    logic slot_emit;
    logic at_end;
    logic can_emit;
    logic drop_need;
  } dp_stat_t;

endpackage

[sv/cslru_if.sv]
// request and response channel interfaces of the connection slot cache
// depends on cslru_pkg
interface cslru_req_if;
  import cslru_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        op;
  logic [CONN_W-1:0]      conn_id;
  logic [PORT_TIME_W-1:0] now;
  logic [PORT_TIME_W-1:0] last_use;
  logic                   is_closed;

  modport source (output valid, output op, output conn_id, output now, output last_use,
                  output is_closed, input ready);
  modport sink (input valid, input op, input conn_id, input now, input last_use,
                input is_closed, output ready);
endinterface

interface cslru_rsp_if;
  import cslru_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CONN_W-1:0] conn_id_out;
  logic [SLOT_W-1:0] slot;
  logic              last;

  modport source (output valid, output kind, output conn_id_out, output slot, output last,
                  input ready);
  modport sink (input valid, input kind, input conn_id_out, input slot, input last,
                output ready);
endinterface

[sv/cslru_ctrl.sv]
// sequencing state machine of the connection slot cache
// depends on cslru_pkg; drives datapath actions from datapath status
module cslru_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [cslru_pkg::OP_W-1:0]  in_op,
  output logic                        in_ready,
  input  cslru_pkg::dp_stat_t         st,
  output cslru_pkg::act_t             act
);
  import cslru_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    act        = ACT_NONE;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          act = ACT_START;
          case (op_t'(in_op)) inside
            OP_INSERT: state_next = st.direct ? ST_FINISH : ST_SCAN;
            OP_UPDATE, OP_FLUSH: state_next = ST_SCAN;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (!st.slot_emit || st.can_emit) begin
          act = ACT_STEP;
          if (st.at_end) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (st.can_emit) begin
          if (st.drop_need) begin
            act = ACT_DROP;
          end else begin
            act        = ACT_FINISH;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[sv/cslru_dp.sv]
// datapath of the connection slot cache: slot memory, valid bits, scan
// registers, config registers and output word register; depends on cslru_pkg
module cslru_dp #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cslru_pkg::act_t                   act,
  output cslru_pkg::dp_stat_t               st,
  input  logic                              cfg_we,
  input  logic [cslru_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cslru_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [cslru_pkg::OP_W-1:0]        op,
  input  logic [cslru_pkg::CONN_W-1:0]      conn_id,
  input  logic [cslru_pkg::PORT_TIME_W-1:0] now,
  input  logic [cslru_pkg::PORT_TIME_W-1:0] last_use,
  input  logic                              is_closed,
  cslru_rsp_if.source                       rsp
);
  import cslru_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW = $clog2(SLOTS + 1);
  localparam int TW = TIME_BITS;

  // config
  logic [SIU_W-1:0]     slots_in_use;
  logic [TIMEOUT_W-1:0] idle_timeout;
  logic [NW-1:0]        n_act;

  // table state
  logic             started;
  logic [SLOTS-1:0] valid;
  logic [CONN_W-1:0] mem_conn [SLOTS];
  logic [TW-1:0]     mem_lu [SLOTS];
  logic              mem_closed [SLOTS];
  logic [CONN_W-1:0] rd_conn;
  logic [TW-1:0]     rd_lu;
  logic              rd_closed;
  logic [IW-1:0]     rd_addr;

  // captured word
  op_t               r_op;
  logic [CONN_W-1:0] r_id;
  logic [TW-1:0]     r_now;
  logic [TW-1:0]     r_lu;
  logic              r_cl;
  logic [63:0]       now_x;
  logic [63:0]       lu_x;

  // scan registers
  logic [IW-1:0]     idx;
  logic              found;
  logic [IW-1:0]     self_slot;
  logic [IW-1:0]     best_slot;
  logic              best_valid;
  logic              best_closed;
  logic [TW-1:0]     best_lu;
  logic [CONN_W-1:0] best_conn;

  // per-slot decode
  logic          in_range;
  logic          cur_valid;
  logic          is_self;
  logic [TW-1:0] diff;
  logic          expired;
  logic          slot_emit;
  logic          direct;

  // finish decode
  kind_t             fin_kind;
  logic [CONN_W-1:0] fin_conn;
  logic [IW-1:0]     fin_slot;
  logic              fin_we;
  logic              fin_started;
  logic              mem_we;

  // output register
  logic              out_valid;
  kind_t             out_kind;
  logic [CONN_W-1:0] out_conn;
  logic [SLOT_W-1:0] out_slot;
  logic              out_last;
  logic              load;
  kind_t             ld_kind;
  logic [CONN_W-1:0] ld_conn;
  logic [SLOT_W-1:0] ld_slot;
  logic              ld_last;

  assign n_act = (32'(slots_in_use) > 32'(SLOTS)) ? NW'(SLOTS) : NW'(slots_in_use);
  assign now_x = 64'(now);
  assign lu_x  = 64'(last_use);

  assign in_range  = NW'(idx) < n_act;
  assign cur_valid = valid[idx];
  assign is_self   = cur_valid && (rd_conn == r_id) && !found;
  assign diff      = r_now - rd_lu;
  assign expired   = (r_now > rd_lu) && (64'(diff) > 64'(idle_timeout));
  assign direct    = (n_act == '0) || !started;

  always_comb begin
    case (r_op)
      OP_INSERT: slot_emit = in_range && cur_valid && !rd_closed && expired && !is_self;
      OP_FLUSH:  slot_emit = in_range && cur_valid && !rd_closed;
      default:   slot_emit = 1'b0;
    endcase
  end

  assign st.direct    = direct;
  assign st.slot_emit = slot_emit;
  assign st.at_end    = (idx == IW'(SLOTS - 1));
  assign st.can_emit  = !out_valid || rsp.ready;
  assign st.drop_need = (r_op == OP_INSERT) && !direct && !found && best_valid && !best_closed;

  always_comb begin
    fin_kind    = KIND_FLUSHED;
    fin_conn    = r_id;
    fin_slot    = '0;
    fin_we      = 1'b0;
    fin_started = 1'b0;
    case (r_op)
      OP_INSERT: begin
        if (n_act == '0) begin
          fin_kind = KIND_OFF;
        end else if (!started) begin
          fin_kind    = KIND_STORED;
          fin_we      = 1'b1;
          fin_started = 1'b1;
        end else if (found) begin
          fin_kind = KIND_CACHED;
          fin_slot = self_slot;
        end else begin
          fin_kind = KIND_STORED;
          fin_slot = best_slot;
          fin_we   = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (found) begin
          fin_kind = KIND_UPDATED;
          fin_slot = self_slot;
          fin_we   = 1'b1;
        end else begin
          fin_kind = KIND_NOT_FOUND;
        end
      end
      default: begin
        fin_kind = KIND_FLUSHED;
        fin_conn = '0;
      end
    endcase
  end

  assign mem_we = (act == ACT_FINISH) && fin_we;

  always_comb begin
    case (act)
      ACT_START: rd_addr = '0;
      ACT_STEP:  rd_addr = idx + IW'(1);
      default:   rd_addr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_conn[fin_slot]   <= r_id;
      mem_lu[fin_slot]     <= r_lu;
      mem_closed[fin_slot] <= r_cl;
    end
    rd_conn   <= mem_conn[rd_addr];
    rd_lu     <= mem_lu[rd_addr];
    rd_closed <= mem_closed[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SIU_RESET;
      idle_timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOTS_IN_USE: slots_in_use <= cfg_data[SIU_W-1:0];
        CFG_IDLE_TIMEOUT: idle_timeout <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      started <= 1'b0;
    end else begin
      if (act == ACT_STEP &&
          (slot_emit || (r_op == OP_FLUSH && in_range && cur_valid))) begin
        valid[idx] <= 1'b0;
      end
      if (mem_we) begin
        valid[fin_slot] <= 1'b1;
      end
      if (act == ACT_FINISH && fin_started) begin
        started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (act)
      ACT_START: begin
        r_op  <= op_t'(op);
        r_id  <= conn_id;
        r_now <= now_x[TW-1:0];
        r_lu  <= lu_x[TW-1:0];
        r_cl  <= is_closed;
        idx   <= '0;
        found <= 1'b0;
      end
      ACT_STEP: begin
        idx <= idx + IW'(1);
        if (is_self) begin
          found     <= 1'b1;
          self_slot <= idx;
        end
        if (r_op == OP_INSERT && in_range) begin
          if (!cur_valid || rd_closed) begin
            best_slot   <= idx;
            best_valid  <= cur_valid;
            best_closed <= rd_closed;
            best_lu     <= rd_lu;
            best_conn   <= rd_conn;
          end else if (slot_emit) begin
            best_slot  <= idx;
            best_valid <= 1'b0;
          end else if (idx == '0 || (best_valid && rd_lu < best_lu)) begin
            best_slot   <= idx;
            best_valid  <= 1'b1;
            best_closed <= 1'b0;
            best_lu     <= rd_lu;
            best_conn   <= rd_conn;
          end
        end
      end
      ACT_DROP: best_valid <= 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    load    = 1'b0;
    ld_kind = KIND_CLOSE;
    ld_conn = rd_conn;
    ld_slot = SLOT_W'(idx);
    ld_last = 1'b0;
    case (act)
      ACT_STEP: load = slot_emit;
      ACT_DROP: begin
        load    = 1'b1;
        ld_conn = best_conn;
        ld_slot = SLOT_W'(best_slot);
      end
      ACT_FINISH: begin
        load    = 1'b1;
        ld_kind = fin_kind;
        ld_conn = fin_conn;
        ld_slot = SLOT_W'(fin_slot);
        ld_last = 1'b1;
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= ld_kind;
      out_conn <= ld_conn;
      out_slot <= ld_slot;
      out_last <= ld_last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_kind;
  assign rsp.conn_id_out = out_conn;
  assign rsp.slot        = out_slot;
  assign rsp.last        = out_last;

endmodule

[sv/connection_slot_cache_lru_aging.sv]
// connection slot cache with least-recently-used replacement and idle expiry
// req channel: one word per operation (insert, update, flush); rsp channel:
// close words for evicted open entries, then one final word with last set.
// config: cfg_we with cfg_index 0 writes slots_in_use, index 1 idle_timeout;
// write only while no operation is in flight.
// timing: a word is taken in the cycle req.ready is high, then the slot
// memory is walked one slot per cycle (while not held, see below) over all
// SLOTS slots for an insert (after the first), update or flush, and a
// replaced open victim gives one more close word. the first insert after
// reset and inserts with caching off skip the walk; op 3 gives no word.
// the walk is set by the single read port of the memory.
// rsp has a one-word output register; while it is full and rsp.ready is low
// the walk holds at any slot that has a close word to give, and req.ready stays low until
// the final word is loaded.
// reset: synchronous rst clears valid bits, the started flag, the output
// register and restores slots_in_use 16 and idle_timeout 300.
// depends on cslru_pkg, cslru_if, cslru_ctrl and cslru_dp
module connection_slot_cache_lru_aging #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cslru_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cslru_pkg::CFG_DATA_W-1:0]  cfg_data,
  cslru_req_if.sink                         req,
  cslru_rsp_if.source                       rsp
);
  import cslru_pkg::*;

  act_t     act;
  dp_stat_t st;

  cslru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_op    (req.op),
    .in_ready (req.ready),
    .st       (st),
    .act      (act)
  );

  cslru_dp #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .act       (act),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (req.op),
    .conn_id   (req.conn_id),
    .now       (req.now),
    .last_use  (req.last_use),
    .is_closed (req.is_closed),
    .rsp       (rsp)
  );

endmodule

[sv/cslru_chk.sv]
// port-level checker for the connection slot cache, bound to the top level
// depends on cslru_pkg and connection_slot_cache_lru_aging_defines.svh
`include "connection_slot_cache_lru_aging_defines.svh"

module cslru_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic [cslru_pkg::OP_W-1:0]  req_op,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [cslru_pkg::KIND_W-1:0] rsp_kind,
  input logic [cslru_pkg::CONN_W-1:0] rsp_conn_id_out,
  input logic [cslru_pkg::SLOT_W-1:0] rsp_slot,
  input logic                        rsp_last
);
  import cslru_pkg::*;

  `CSLRU_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_conn_id_out) && $stable(rsp_slot) && $stable(rsp_last), "stalled response word changed")
  `CSLRU_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready && (req_op == OP_INSERT || req_op == OP_UPDATE || req_op == OP_FLUSH), !req_ready, "request taken while previous operation in flight")
  `CSLRU_ASSERT_IMP(a_close_not_last, clk, rst, rsp_valid && !rsp_last, rsp_kind == KIND_CLOSE, "non-final word is not a close")
  `CSLRU_ASSERT_IMP(a_flush_word, clk, rst, rsp_valid && rsp_kind == KIND_FLUSHED, rsp_conn_id_out == '0 && rsp_slot == '0 && rsp_last, "malformed flush word")

endmodule

bind connection_slot_cache_lru_aging cslru_chk u_chk (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_op          (req.op),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_kind        (rsp.kind),
  .rsp_conn_id_out (rsp.conn_id_out),
  .rsp_slot        (rsp.slot),
  .rsp_last        (rsp.last)
);
